// ===== hw/rtl/acc_pkg.sv =====
// acc_pkg: shared constants, types and command structs for the accumulator execute block
// used by acc_ctrl, acc_dpath and accumulator_cpu_execute_top
`timescale 1ns / 1ps
package acc_pkg;
  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_HWR   = 2'd1;
  localparam logic [1:0] MODE_HRD   = 2'd2;

  localparam logic [7:0] OP_MATH_BIT = 8'h80;
  localparam logic [7:0] OP_BR_MASK  = 8'hF8;
  localparam logic [7:0] OP_BR_BASE  = 8'h10;

  localparam logic [1:0] LOC_MEM_AR  = 2'd0;
  localparam logic [1:0] LOC_ACC     = 2'd1;
  localparam logic [1:0] LOC_AR      = 2'd2;
  localparam logic [1:0] LOC_MEM_OP  = 2'd3;

  localparam logic [2:0] FN_AND = 3'd0;
  localparam logic [2:0] FN_OR  = 3'd1;
  localparam logic [2:0] FN_XOR = 3'd2;
  localparam logic [2:0] FN_ADD = 3'd3;
  localparam logic [2:0] FN_SUB = 3'd4;
  localparam logic [2:0] FN_INC = 3'd5;
  localparam logic [2:0] FN_DEC = 3'd6;
  localparam logic [2:0] FN_NOT = 3'd7;

  localparam logic [1:0] METH_IND   = 2'd0;
  localparam logic [1:0] METH_CONST = 2'd1;
  localparam logic [1:0] METH_AR    = 2'd2;
  localparam logic [1:0] METH_NONE  = 2'd3;

  // memory address source selects
  typedef enum logic [2:0] {
    AS_HOST, AS_NEAR, AS_NEAR1, AS_FAR, AS_AR, AS_AR1, AS_T, AS_T1
  } asel_e;

  // write data selects
  typedef enum logic [1:0] {
    WS_HOST, WS_RES, WS_ARHI, WS_ARLO
  } wsel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_WR1, ST_WR2, ST_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic        capture;   // latch input item
    logic        mem_re;
    logic        mem_we;
    asel_e       asel;
    wsel_e       wsel;
    logic        ld_b1;     // latch first read byte
    logic        ld_b2;     // latch second read byte
    logic        ld_b3;
    logic        commit;    // update acc / ar / result registers, fire strobe
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] opcode;
  } sts_t;
endpackage

// ===== hw/rtl/acc_ram.sv =====
// acc_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module acc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/acc_ctrl.sv =====
// acc_ctrl: sequencer state machine issuing memory reads, writes and commit
// depends on acc_pkg
`timescale 1ns / 1ps
module acc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  acc_pkg::sts_t sts_i,
  output acc_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  acc_pkg::state_e state_q, state_d;
  logic [1:0] mode;
  logic [7:0] op;
  logic is_math, is_mem, load, to_mar, d16;
  logic [1:0] dsel, ssel, meth;

  assign mode = sts_i.mode;
  assign op = sts_i.opcode;
  assign is_math = (mode == acc_pkg::MODE_EXEC) && op[7];
  assign is_mem  = (mode == acc_pkg::MODE_EXEC) && (op[7:4] == 4'h0)
                   && (op[1:0] != acc_pkg::METH_NONE);
  assign dsel = op[3:2];
  assign ssel = op[1:0];
  assign meth = op[1:0];
  assign load = op[3];
  assign to_mar = op[2];
  assign d16 = (dsel == acc_pkg::LOC_AR);

  // read plan: math reads dest byte (rd1), source byte(s) (rd2, rd3)
  // memory op indirect store reads pointer (rd1); loads read (rd1, rd2)
  logic need_rd1, need_rd2, need_rd3, need_wr1, need_wr2;
  acc_pkg::asel_e a1, a2, a3, aw1, aw2;
  acc_pkg::wsel_e w1, w2;

  always_comb begin
    need_rd1 = 1'b0; need_rd2 = 1'b0; need_rd3 = 1'b0;
    need_wr1 = 1'b0; need_wr2 = 1'b0;
    a1 = acc_pkg::AS_HOST; a2 = acc_pkg::AS_HOST; a3 = acc_pkg::AS_HOST;
    aw1 = acc_pkg::AS_HOST; aw2 = acc_pkg::AS_HOST;
    w1 = acc_pkg::WS_RES; w2 = acc_pkg::WS_RES;
    if (mode == acc_pkg::MODE_HWR) begin
      need_wr1 = 1'b1; w1 = acc_pkg::WS_HOST;
    end else if (mode == acc_pkg::MODE_HRD) begin
      need_rd1 = 1'b1;
    end else if (is_math) begin
      if (dsel == acc_pkg::LOC_MEM_AR) begin
        need_rd1 = 1'b1; a1 = acc_pkg::AS_AR; need_wr1 = 1'b1; aw1 = acc_pkg::AS_AR;
      end else if (dsel == acc_pkg::LOC_MEM_OP) begin
        need_rd1 = 1'b1; a1 = op[1] ? acc_pkg::AS_FAR : acc_pkg::AS_NEAR;
        need_wr1 = 1'b1; aw1 = a1;
      end
      if (ssel == acc_pkg::LOC_MEM_AR) begin
        need_rd2 = 1'b1; a2 = acc_pkg::AS_AR;
      end else if (ssel == acc_pkg::LOC_MEM_OP) begin
        need_rd2 = 1'b1; a2 = acc_pkg::AS_NEAR;
        if (d16) begin
          need_rd3 = 1'b1; a3 = acc_pkg::AS_NEAR1;
        end
      end
    end else if (is_mem) begin
      if (!load) begin
        if (meth == acc_pkg::METH_IND) begin
          need_rd1 = 1'b1; a1 = acc_pkg::AS_NEAR;
          aw1 = acc_pkg::AS_T; aw2 = acc_pkg::AS_T1;
        end else if (meth == acc_pkg::METH_CONST) begin
          aw1 = acc_pkg::AS_NEAR; aw2 = acc_pkg::AS_NEAR1;
        end else begin
          aw1 = acc_pkg::AS_AR; aw2 = acc_pkg::AS_AR1;
        end
        need_wr1 = 1'b1;
        if (to_mar) begin
          need_wr2 = 1'b1; w1 = acc_pkg::WS_ARHI; w2 = acc_pkg::WS_ARLO;
        end else begin
          w1 = acc_pkg::WS_RES;
        end
      end else if (meth != acc_pkg::METH_CONST) begin
        need_rd1 = 1'b1;
        a1 = (meth == acc_pkg::METH_IND) ? acc_pkg::AS_NEAR : acc_pkg::AS_AR;
        if (to_mar) begin
          need_rd2 = 1'b1;
          a2 = (meth == acc_pkg::METH_IND) ? acc_pkg::AS_NEAR1 : acc_pkg::AS_AR1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= acc_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acc_pkg::ST_IDLE: if (start_i) state_d = acc_pkg::ST_RD1;
      acc_pkg::ST_RD1:  state_d = acc_pkg::ST_RD2;
      acc_pkg::ST_RD2:  state_d = acc_pkg::ST_RD3;
      acc_pkg::ST_RD3:  state_d = acc_pkg::ST_WR1;
      acc_pkg::ST_WR1:  state_d = acc_pkg::ST_WR2;
      acc_pkg::ST_WR2:  state_d = acc_pkg::ST_DONE;
      acc_pkg::ST_DONE: state_d = acc_pkg::ST_IDLE;
      default:          state_d = acc_pkg::ST_IDLE;
    endcase
  end

  // outputs; each read lands in the following state, where the datapath latches it
  always_comb begin
    cmd_o = '0;
    cmd_o.asel = acc_pkg::AS_HOST;
    cmd_o.wsel = acc_pkg::WS_RES;
    busy_o = (state_q != acc_pkg::ST_IDLE);
    unique case (state_q)
      acc_pkg::ST_IDLE: cmd_o.capture = start_i;
      acc_pkg::ST_RD1: begin
        cmd_o.mem_re = need_rd1; cmd_o.asel = a1;
      end
      acc_pkg::ST_RD2: begin
        cmd_o.ld_b1 = 1'b1; cmd_o.mem_re = need_rd2; cmd_o.asel = a2;
      end
      acc_pkg::ST_RD3: begin
        cmd_o.ld_b2 = 1'b1; cmd_o.mem_re = need_rd3; cmd_o.asel = a3;
      end
      acc_pkg::ST_WR1: begin
        cmd_o.ld_b3 = 1'b1; cmd_o.mem_we = need_wr1; cmd_o.asel = aw1;
        cmd_o.wsel = w1;
      end
      acc_pkg::ST_WR2: begin
        cmd_o.mem_we = need_wr2; cmd_o.asel = aw2; cmd_o.wsel = w2;
      end
      acc_pkg::ST_DONE: cmd_o.commit = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/acc_dpath.sv =====
// acc_dpath: accumulator, address register, alu, memory and result registers
// depends on acc_pkg and acc_ram
`timescale 1ns / 1ps
module acc_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  acc_pkg::cmd_t cmd_i,
  output acc_pkg::sts_t sts_o,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    opcode_i,
  input  logic [15:0]   operand_far_i,
  input  logic [15:0]   operand_near_i,
  input  logic [15:0]   host_address_i,
  input  logic [7:0]    host_data_i,
  output logic          done_o,
  output logic [7:0]    acc_value_o,
  output logic [15:0]   address_reg_value_o,
  output logic          branch_taken_o,
  output logic [15:0]   branch_target_o,
  output logic [7:0]    read_data_o
);
  localparam int unsigned AW = acc_pkg::ADDR_BITS;

  logic [1:0]  mode_q;
  logic [7:0]  op_q, hdata_q;
  logic [15:0] far_q, near_q, haddr_q;
  logic [7:0]  b1_q, b2_q, b3_q;
  logic [7:0]  acc_q, acc_d;
  logic [15:0] ar_q, ar_d;
  logic        taken_q, taken_d, done_q;
  logic [15:0] target_q, target_d;
  logic [7:0]  rdata_q, rdata_d;
  logic [7:0]  mem_rd, mem_wd;
  logic [15:0] maddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i; op_q <= opcode_i; far_q <= operand_far_i;
      near_q <= operand_near_i; haddr_q <= host_address_i; hdata_q <= host_data_i;
    end
    if (cmd_i.ld_b1) b1_q <= mem_rd;
    if (cmd_i.ld_b2) b2_q <= mem_rd;
    if (cmd_i.ld_b3) b3_q <= mem_rd;
  end

  assign sts_o.mode = mode_q;
  assign sts_o.opcode = op_q;

  logic [1:0] dsel, ssel;
  logic       d16, is_math, is_mem, is_br;
  assign dsel = op_q[3:2];
  assign ssel = op_q[1:0];
  assign d16 = (dsel == acc_pkg::LOC_AR);
  assign is_math = (mode_q == acc_pkg::MODE_EXEC) && op_q[7];
  assign is_mem = (mode_q == acc_pkg::MODE_EXEC) && (op_q[7:4] == 4'h0);
  assign is_br = (mode_q == acc_pkg::MODE_EXEC)
                 && ((op_q & acc_pkg::OP_BR_MASK) == acc_pkg::OP_BR_BASE);

  // alu; b1 holds the memory destination byte, b2/b3 the memory source
  logic [15:0] dv, sv, res;
  always_comb begin
    unique case (dsel)
      acc_pkg::LOC_ACC: dv = {8'h00, acc_q};
      acc_pkg::LOC_AR:  dv = ar_q;
      default:          dv = {8'h00, b1_q};
    endcase
    unique case (ssel)
      acc_pkg::LOC_MEM_AR: sv = {8'h00, b2_q};
      acc_pkg::LOC_ACC:    sv = {8'h00, acc_q};
      acc_pkg::LOC_AR:     sv = d16 ? near_q : {8'h00, near_q[7:0]};
      default:             sv = d16 ? {b2_q, b3_q} : {8'h00, b2_q};
    endcase
    unique case (op_q[6:4])
      acc_pkg::FN_AND: res = dv & sv;
      acc_pkg::FN_OR:  res = dv | sv;
      acc_pkg::FN_XOR: res = dv ^ sv;
      acc_pkg::FN_ADD: res = dv + sv;
      acc_pkg::FN_SUB: res = dv - sv;
      acc_pkg::FN_INC: res = dv + 16'd1;
      acc_pkg::FN_DEC: res = dv - 16'd1;
      default:         res = ~dv;
    endcase
  end

  // memory address and data selection
  logic [15:0] ptr;
  assign ptr = {8'h00, b1_q};
  always_comb begin
    unique case (cmd_i.asel)
      acc_pkg::AS_HOST:  maddr = haddr_q;
      acc_pkg::AS_NEAR:  maddr = near_q;
      acc_pkg::AS_NEAR1: maddr = near_q + 16'd1;
      acc_pkg::AS_FAR:   maddr = far_q;
      acc_pkg::AS_AR:    maddr = ar_q;
      acc_pkg::AS_AR1:   maddr = ar_q + 16'd1;
      acc_pkg::AS_T:     maddr = ptr;
      default:           maddr = ptr + 16'd1;
    endcase
    unique case (cmd_i.wsel)
      acc_pkg::WS_HOST: mem_wd = hdata_q;
      acc_pkg::WS_RES:  mem_wd = is_math ? res[7:0] : acc_q;
      acc_pkg::WS_ARHI: mem_wd = ar_q[15:8];
      default:          mem_wd = ar_q[7:0];
    endcase
  end

  acc_ram #(.WIDTH(8), .DEPTH(acc_pkg::MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .re_i    (cmd_i.mem_re),
    .addr_i  (maddr[AW-1:0]),
    .wdata_i (mem_wd),
    .rdata_o (mem_rd)
  );

  // commit
  logic neg, zero, cond;
  assign neg = acc_q[7];
  assign zero = (acc_q == 8'h00);
  always_comb begin
    unique case (op_q[2:0])
      3'd0: cond = 1'b1;
      3'd1: cond = zero;
      3'd2: cond = !zero;
      3'd3: cond = neg;
      3'd4: cond = neg || zero;
      3'd5: cond = !neg && !zero;
      3'd6: cond = !neg;
      default: cond = 1'b0;
    endcase
    acc_d = acc_q; ar_d = ar_q;
    taken_d = 1'b0; target_d = 16'h0000; rdata_d = 8'h00;
    if (is_math) begin
      if (dsel == acc_pkg::LOC_ACC) acc_d = res[7:0];
      if (dsel == acc_pkg::LOC_AR) ar_d = res;
    end else if (is_mem && (op_q[1:0] != acc_pkg::METH_NONE) && op_q[3]) begin
      if (!op_q[2]) begin
        acc_d = (op_q[1:0] == acc_pkg::METH_CONST) ? near_q[7:0] : b1_q;
      end else begin
        ar_d = (op_q[1:0] == acc_pkg::METH_CONST) ? near_q : {b1_q, b2_q};
      end
    end else if (is_br && cond) begin
      taken_d = 1'b1; target_d = near_q;
    end else if (mode_q == acc_pkg::MODE_HRD) begin
      rdata_d = b1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00; ar_q <= 16'h0000; done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        acc_q <= acc_d; ar_q <= ar_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      taken_q <= taken_d; target_q <= target_d; rdata_q <= rdata_d;
    end
  end

  assign done_o = done_q;
  assign acc_value_o = acc_q;
  assign address_reg_value_o = ar_q;
  assign branch_taken_o = taken_q;
  assign branch_target_o = target_q;
  assign read_data_o = rdata_q;
endmodule

// ===== hw/rtl/accumulator_cpu_execute_top.sv =====
// accumulator_cpu_execute_top: execute stage of an 8-bit accumulator machine
// depends on acc_pkg, acc_ctrl, acc_dpath and acc_ram
// the sequencer steps rd1, rd2, rd3, wr1, wr2, done; done_o is registered from the commit
// no item overlaps a pending result; busy stays high from the accepting edge through the
// result strobe cycle; the receiver cannot stall, every result is taken in its strobe cycle
// the single memory port sets the pace: three read slots and two write slots per item
// reset clears accumulator, address register and the sequencer; memory is not cleared
`timescale 1ns / 1ps
module accumulator_cpu_execute_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] operand_far_i,
  input  logic [15:0] operand_near_i,
  input  logic [15:0] host_address_i,
  input  logic [7:0]  host_data_i,
  output logic        done_o,
  output logic [7:0]  acc_value_o,
  output logic [15:0] address_reg_value_o,
  output logic        branch_taken_o,
  output logic [15:0] branch_target_o,
  output logic [7:0]  read_data_o
);
  // command and status between sequencer and datapath
  acc_pkg::cmd_t cmd;
  acc_pkg::sts_t sts;
  logic ctrl_busy;
  logic ctrl_start;

  // the sequencer is already idle in the strobe cycle, so hold start off there
  assign ctrl_start = start & ~done_o;

  acc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  // capture happens on the start edge, so status reflects the item from rd1 on
  acc_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .mode_i              (mode_i),
    .opcode_i            (opcode_i),
    .operand_far_i       (operand_far_i),
    .operand_near_i      (operand_near_i),
    .host_address_i      (host_address_i),
    .host_data_i         (host_data_i),
    .done_o              (done_o),
    .acc_value_o         (acc_value_o),
    .address_reg_value_o (address_reg_value_o),
    .branch_taken_o      (branch_taken_o),
    .branch_target_o     (branch_target_o),
    .read_data_o         (read_data_o)
  );

  // busy covers the strobe cycle too, so no item overlaps a pending result
  assign busy = ctrl_busy | done_o;
endmodule

// ===== sim/tb_accumulator_cpu_execute_top.sv =====
// tb_accumulator_cpu_execute_top: self-checking testbench for the accumulator execute block
// depends on acc_pkg and accumulator_cpu_execute_top; runs directed then random items
// with a built-in predictor, bursty start timing and a cycle watchdog
`timescale 1ns / 1ps
module tb_accumulator_cpu_execute_top;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 1300;
  localparam logic [7:0]  SIGN_BIT       = 8'h80;

  // one command item as driven onto the ports
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  opcode;
    logic [15:0] far;
    logic [15:0] near;
    logic [15:0] haddr;
    logic [7:0]  hdata;
  } exec_item_t;

  // architectural state reported after each item
  typedef struct {
    logic [7:0]  acc;
    logic [15:0] areg;
    logic        taken;
    logic [15:0] target;
    logic [7:0]  rdata;
  } step_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  mode_i;
  logic [7:0]  opcode_i;
  logic [15:0] operand_far_i;
  logic [15:0] operand_near_i;
  logic [15:0] host_address_i;
  logic [7:0]  host_data_i;
  logic        done_o;
  logic [7:0]  acc_value_o;
  logic [15:0] address_reg_value_o;
  logic        branch_taken_o;
  logic [15:0] branch_target_o;
  logic [7:0]  read_data_o;

  accumulator_cpu_execute_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .mode_i              (mode_i),
    .opcode_i            (opcode_i),
    .operand_far_i       (operand_far_i),
    .operand_near_i      (operand_near_i),
    .host_address_i      (host_address_i),
    .host_data_i         (host_data_i),
    .done_o              (done_o),
    .acc_value_o         (acc_value_o),
    .address_reg_value_o (address_reg_value_o),
    .branch_taken_o      (branch_taken_o),
    .branch_target_o     (branch_target_o),
    .read_data_o         (read_data_o)
  );

  // predictor state: our own copy of the machine
  logic [7:0]  model_acc;
  logic [15:0] model_areg;
  logic [7:0]  model_mem [0:65535];
  bit          mem_written [0:65535];

  step_state_t expected_steps[$];
  logic [15:0] bytes_read[$];
  logic [15:0] addr_pool[16];

  bit          failed;
  int unsigned idle_cycles;
  int unsigned burst_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // list the memory bytes an item will read, given the current predicted state
  task automatic list_reads(input exec_item_t it);
    logic [1:0]  dsel;
    logic [1:0]  meth;
    logic [15:0] daddr;
    bytes_read = {};
    if (it.mode == acc_pkg::MODE_HRD) begin
      bytes_read.push_back(it.haddr);
    end else if (it.mode == acc_pkg::MODE_EXEC) begin
      if (it.opcode[7]) begin
        dsel  = it.opcode[3:2];
        daddr = it.opcode[1] ? it.far : it.near;
        if (dsel == acc_pkg::LOC_MEM_AR) bytes_read.push_back(model_areg);
        if (dsel == acc_pkg::LOC_MEM_OP) bytes_read.push_back(daddr);
        // source select shares the location codes: 0 memory at ar, 3 memory at near
        if (it.opcode[1:0] == acc_pkg::LOC_MEM_AR) bytes_read.push_back(model_areg);
        if (it.opcode[1:0] == acc_pkg::LOC_MEM_OP) begin
          bytes_read.push_back(it.near);
          if (dsel == acc_pkg::LOC_AR) bytes_read.push_back(it.near + 16'd1);
        end
      end else if (it.opcode[7:4] == 4'h0) begin
        meth = it.opcode[1:0];
        if (!it.opcode[3]) begin
          if (meth == acc_pkg::METH_IND) bytes_read.push_back(it.near);
        end else if (!it.opcode[2]) begin
          if (meth == acc_pkg::METH_IND) bytes_read.push_back(it.near);
          if (meth == acc_pkg::METH_AR) bytes_read.push_back(model_areg);
        end else begin
          if (meth == acc_pkg::METH_IND) begin
            bytes_read.push_back(it.near);
            bytes_read.push_back(it.near + 16'd1);
          end
          if (meth == acc_pkg::METH_AR) begin
            bytes_read.push_back(model_areg);
            bytes_read.push_back(model_areg + 16'd1);
          end
        end
      end
    end
  endtask

  task automatic mem_store(input logic [15:0] a, input logic [7:0] v);
    model_mem[a]   = v;
    mem_written[a] = 1'b1;
  endtask

  // advance the predicted machine by one accepted item and queue what it should report
  task automatic predict_step(input exec_item_t it);
    step_state_t res;
    logic [1:0]  dsel;
    logic [1:0]  meth;
    logic [15:0] daddr;
    logic [15:0] dst;
    logic [15:0] src;
    logic [15:0] mask;
    logic [15:0] a;
    bit          neg;
    bit          zero;
    bit          cond;
    res = '{acc: 8'h00, areg: 16'h0000, taken: 1'b0, target: 16'h0000, rdata: 8'h00};
    if (it.mode == acc_pkg::MODE_EXEC) begin
      if (it.opcode[7]) begin
        dsel  = it.opcode[3:2];
        daddr = it.opcode[1] ? it.far : it.near;
        mask  = (dsel == acc_pkg::LOC_AR) ? 16'hFFFF : 16'h00FF;
        case (dsel)
          acc_pkg::LOC_MEM_AR: dst = {8'h00, model_mem[model_areg]};
          acc_pkg::LOC_ACC:    dst = {8'h00, model_acc};
          acc_pkg::LOC_AR:     dst = model_areg;
          default:             dst = {8'h00, model_mem[daddr]};
        endcase
        case (it.opcode[1:0])
          acc_pkg::LOC_MEM_AR: src = {8'h00, model_mem[model_areg]};
          acc_pkg::LOC_ACC:    src = {8'h00, model_acc};
          acc_pkg::LOC_AR:     src = (dsel == acc_pkg::LOC_AR) ? it.near
                                                               : {8'h00, it.near[7:0]};
          default:             src = (dsel == acc_pkg::LOC_AR) ?
                                     {model_mem[it.near], model_mem[it.near + 16'd1]} :
                                     {8'h00, model_mem[it.near]};
        endcase
        case (it.opcode[6:4])
          acc_pkg::FN_AND: dst = dst & src;
          acc_pkg::FN_OR:  dst = dst | src;
          acc_pkg::FN_XOR: dst = dst ^ src;
          acc_pkg::FN_ADD: dst = dst + src;
          acc_pkg::FN_SUB: dst = dst - src;
          acc_pkg::FN_INC: dst = dst + 16'd1;
          acc_pkg::FN_DEC: dst = dst - 16'd1;
          default:         dst = ~dst;
        endcase
        dst = dst & mask;
        case (dsel)
          acc_pkg::LOC_MEM_AR: mem_store(model_areg, dst[7:0]);
          acc_pkg::LOC_ACC:    model_acc = dst[7:0];
          acc_pkg::LOC_AR:     model_areg = dst;
          default:             mem_store(daddr, dst[7:0]);
        endcase
      end else if (it.opcode[7:4] == 4'h0) begin
        meth = it.opcode[1:0];
        if (meth != acc_pkg::METH_NONE) begin
          if (!it.opcode[3]) begin
            // store: indirect takes the target address from the byte at near
            if (meth == acc_pkg::METH_IND) a = {8'h00, model_mem[it.near]};
            else if (meth == acc_pkg::METH_CONST) a = it.near;
            else a = model_areg;
            if (it.opcode[2]) begin
              mem_store(a, model_areg[15:8]);
              mem_store(a + 16'd1, model_areg[7:0]);
            end else begin
              mem_store(a, model_acc);
            end
          end else if (!it.opcode[2]) begin
            if (meth == acc_pkg::METH_IND) model_acc = model_mem[it.near];
            else if (meth == acc_pkg::METH_CONST) model_acc = it.near[7:0];
            else model_acc = model_mem[model_areg];
          end else begin
            if (meth == acc_pkg::METH_IND)
              model_areg = {model_mem[it.near], model_mem[it.near + 16'd1]};
            else if (meth == acc_pkg::METH_CONST) model_areg = it.near;
            else model_areg = {model_mem[model_areg], model_mem[model_areg + 16'd1]};
          end
        end
      end else if ((it.opcode & acc_pkg::OP_BR_MASK) == acc_pkg::OP_BR_BASE) begin
        neg  = (model_acc & SIGN_BIT) != 8'h00;
        zero = model_acc == 8'h00;
        case (it.opcode[2:0])
          3'd0:    cond = 1'b1;
          3'd1:    cond = zero;
          3'd2:    cond = !zero;
          3'd3:    cond = neg;
          3'd4:    cond = neg || zero;
          3'd5:    cond = !neg && !zero;
          3'd6:    cond = !neg;
          default: cond = 1'b0;
        endcase
        if (cond) begin
          res.taken  = 1'b1;
          res.target = it.near;
        end
      end
    end else if (it.mode == acc_pkg::MODE_HWR) begin
      mem_store(it.haddr, it.hdata);
    end else if (it.mode == acc_pkg::MODE_HRD) begin
      res.rdata = model_mem[it.haddr];
    end
    res.acc  = model_acc;
    res.areg = model_areg;
    expected_steps.push_back(res);
  endtask

  // drive one item from a falling edge, wait for it to be taken, then maybe pause
  task automatic drive_item(input exec_item_t it);
    int unsigned gap;
    @(negedge clk_i);
    start          = 1'b1;
    mode_i         = it.mode;
    opcode_i       = it.opcode;
    operand_far_i  = it.far;
    operand_near_i = it.near;
    host_address_i = it.haddr;
    host_data_i    = it.hdata;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_step(it);
    // bursts of back-to-back items separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // send an item, first host-writing any byte it would read that was never written
  task automatic send_item(input exec_item_t it);
    exec_item_t fill;
    logic [15:0] need[$];
    list_reads(it);
    need = bytes_read;
    foreach (need[i]) begin
      if (!mem_written[need[i]]) begin
        fill = '{mode: acc_pkg::MODE_HWR, opcode: 8'($urandom), far: 16'($urandom),
                 near: 16'($urandom), haddr: need[i], hdata: 8'($urandom)};
        drive_item(fill);
      end
    end
    drive_item(it);
  endtask

  function automatic exec_item_t make_item(input logic [1:0] mode, input logic [7:0] op,
                                           input logic [15:0] far, input logic [15:0] near);
    exec_item_t it;
    it = '{mode: mode, opcode: op, far: far, near: near,
           haddr: 16'($urandom), hdata: 8'($urandom)};
    return it;
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return addr_pool[$urandom_range(0, 15)];
    return 16'($urandom);
  endfunction

  // result checker: the strobe cannot be held off, every strobe is compared
  always @(posedge clk_i) begin
    step_state_t exp_s;
    if (rst_ni && done_o) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected result acc=%h ar=%h", $time, acc_value_o,
                 address_reg_value_o);
        failed = 1'b1;
      end else begin
        exp_s = expected_steps.pop_front();
        if (acc_value_o !== exp_s.acc) begin
          $display("%0t: acc_value exp %h got %h", $time, exp_s.acc, acc_value_o);
          failed = 1'b1;
        end
        if (address_reg_value_o !== exp_s.areg) begin
          $display("%0t: address_reg_value exp %h got %h", $time, exp_s.areg,
                   address_reg_value_o);
          failed = 1'b1;
        end
        if (branch_taken_o !== exp_s.taken) begin
          $display("%0t: branch_taken exp %h got %h", $time, exp_s.taken, branch_taken_o);
          failed = 1'b1;
        end
        if (branch_target_o !== exp_s.target) begin
          $display("%0t: branch_target exp %h got %h", $time, exp_s.target,
                   branch_target_o);
          failed = 1'b1;
        end
        if (read_data_o !== exp_s.rdata) begin
          $display("%0t: read_data exp %h got %h", $time, exp_s.rdata, read_data_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // host writes at the address extremes, reads back, and the unused mode
  task automatic test_host_access();
    exec_item_t it;
    it = make_item(acc_pkg::MODE_HWR, 8'h00, 16'h0000, 16'h0000);
    it.haddr = 16'h0000; it.hdata = 8'h00; send_item(it);
    it.haddr = 16'hFFFF; it.hdata = 8'hFF; send_item(it);
    it.mode = acc_pkg::MODE_HRD; send_item(it);
    it.haddr = 16'h0000; send_item(it);
    send_item(make_item(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF));
  endtask

  // every math function, over the destinations and sources, with wrap-around
  task automatic test_math_ops();
    logic [2:0] fn;
    send_item(make_item(acc_pkg::MODE_EXEC, 8'h09, 16'h0000, 16'h00FF));   // acc = 0xff
    for (int i = 0; i < 8; i++) begin
      fn = 3'(i);
      send_item(make_item(acc_pkg::MODE_EXEC, {1'b1, fn, 2'(i % 4), 2'((i + 2) % 4)},
                          16'hFFFF - 16'(i), 16'(i * 16'h2041)));
    end
  endtask

  // all load and store opcodes, including the no-op addressing method
  task automatic test_memory_ops();
    for (int i = 0; i < 16; i++)
      send_item(make_item(acc_pkg::MODE_EXEC, 8'(i), 16'h1234,
                          (i % 2) ? 16'hFFFE : 16'h0080));
  endtask

  // branches on zero, negative and positive accumulator values
  task automatic test_branches();
    logic [7:0] acc_val [3];
    acc_val = '{8'h00, 8'h80, 8'h7F};
    for (int i = 0; i < 8; i++) begin
      if (i % 3 == 0)
        send_item(make_item(acc_pkg::MODE_EXEC, 8'h09, 16'h0000, {8'h00, acc_val[i / 3]}));
      send_item(make_item(acc_pkg::MODE_EXEC, acc_pkg::OP_BR_BASE | 8'(i), 16'h0000,
                          16'hA55A ^ 16'(i)));
    end
  endtask

  // random mix, mostly well-formed instructions with addresses from a small pool
  task automatic test_random();
    exec_item_t it;
    int unsigned kind;
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      it = make_item(acc_pkg::MODE_EXEC, 8'($urandom), pick_addr(), pick_addr());
      it.haddr = pick_addr();
      if (kind < 35)      it.opcode[7] = 1'b1;
      else if (kind < 60) it.opcode = 8'($urandom_range(0, 15));
      else if (kind < 75) it.opcode = acc_pkg::OP_BR_BASE | 8'($urandom_range(0, 7));
      else if (kind < 85) it.mode = acc_pkg::MODE_HWR;
      else if (kind < 93) it.mode = acc_pkg::MODE_HRD;
      else if (kind < 97) it.opcode = 8'($urandom_range(8'h18, 8'h7F));
      else                it.mode = 2'd3;
      // constant sources sometimes take random full-width values
      if (kind < 60 && $urandom_range(0, 3) == 0) it.near = 16'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    failed         = 1'b0;
    burst_left     = 0;
    idle_cycles    = 0;
    model_acc      = 8'h00;
    model_areg     = 16'h0000;
    foreach (mem_written[i]) mem_written[i] = 1'b0;
    start          = 1'b0;
    mode_i         = acc_pkg::MODE_EXEC;
    opcode_i       = 8'h00;
    operand_far_i  = 16'h0000;
    operand_near_i = 16'h0000;
    host_address_i = 16'h0000;
    host_data_i    = 8'h00;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_host_access();
    test_math_ops();
    test_memory_ops();
    test_branches();
    test_random();

    @(negedge clk_i);
    start = 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
